@@ src/vsom_pkg.sv @@
// shared types and constants for the voxel slice obstacle marker
`default_nettype none
package vsom_pkg;

    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 128;
    localparam int MAX_SLICES  = 16;
    localparam int FRAC_BITS   = 16;

    localparam int COL_BITS   = $clog2(MAX_COLUMNS);
    localparam int ROW_BITS   = $clog2(MAX_ROWS);
    localparam int SLICE_BITS = $clog2(MAX_SLICES);
    localparam int ADDR_BITS  = SLICE_BITS + ROW_BITS + COL_BITS;
    localparam int CELL_BITS  = FRAC_BITS + 2;

    // 33-bit integer quotient, then fraction bits for z
    localparam int INT_STEPS  = 33;
    localparam int DIV_BITS   = INT_STEPS + FRAC_BITS;
    localparam int CNT_BITS   = $clog2(DIV_BITS);

    localparam logic [FRAC_BITS:0] DIFF_LIMIT = (FRAC_BITS + 1)'((5 * (2 ** FRAC_BITS)) / 100);
    localparam logic [FRAC_BITS:0] ONE_FRAC   = (FRAC_BITS + 1)'(2 ** FRAC_BITS);
    localparam logic [33:0] RAISE_EPS = 34'd66;
    localparam logic [33:0] Q_MAX     = 34'h0_7FFF_FFFF;

    localparam logic [30:0] PIXEL_RESET  = 31'd65536;
    localparam logic [30:0] SLICE_RESET  = 31'd65536;
    localparam logic [7:0]  WIDTH_RESET  = 8'(MAX_COLUMNS);
    localparam logic [7:0]  HEIGHT_RESET = 8'(MAX_ROWS);
    localparam logic [4:0]  COUNT_RESET  = 5'(MAX_SLICES);

    typedef enum logic [2:0] {
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_ORIGIN_Z,
        REG_PIXEL_SIZE,
        REG_SLICE_HEIGHT,
        REG_GRID_WIDTH,
        REG_GRID_HEIGHT,
        REG_SLICE_COUNT
    } vsom_reg_t;

    typedef struct packed {
        logic [31:0] origin_x;
        logic [31:0] origin_y;
        logic [31:0] origin_z;
        logic [30:0] pixel_size;
        logic [30:0] slice_height;
        logic [7:0]  grid_width;
        logic [7:0]  grid_height;
        logic [4:0]  slice_count;
    } vsom_cfg_t;

    typedef struct packed {
        logic [31:0]           x;
        logic [31:0]           y;
        logic [31:0]           z;
        logic [SLICE_BITS-1:0] sl;
        logic [ROW_BITS-1:0]   row;
        logic [COL_BITS-1:0]   col;
        logic [FRAC_BITS-1:0]  frac;
    } vsom_job_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_X,
        F_Y,
        F_Z,
        F_EMIT
    } vsom_front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_CALC,
        B_RAISE
    } vsom_back_state_t;

    // register value zero means one, above the maximum means the maximum
    function automatic logic [7:0] used_size(input logic [7:0] v, input logic [7:0] maxv);
        logic [7:0] r;
        begin
            if (v == 8'd0)
                r = 8'd1;
            else if (v > maxv)
                r = maxv;
            else
                r = v;
            return r;
        end
    endfunction

    function automatic logic [30:0] nonzero(input logic [30:0] v);
        begin
            return (v == 31'd0) ? 31'd1 : v;
        end
    endfunction

endpackage
`default_nettype wire

@@ src/vsom_front.sv @@
// front end: serial divider for column, row, slice and height fraction
`default_nettype none
module vsom_front
    import vsom_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] point_x,
    input  logic [31:0] point_y,
    input  logic [31:0] point_z,
    input  vsom_cfg_t   cfg,
    input  logic        job_full,
    output logic        busy,
    output logic        job_valid,
    output vsom_job_t   job
);

    vsom_front_state_t state_reg, state_next;

    logic [31:0]          px_reg, py_reg, pz_reg;
    logic [DIV_BITS-1:0]  dividend_reg, quot_reg;
    logic [30:0]          rem_reg;
    logic [CNT_BITS-1:0]  count_reg;
    logic [COL_BITS-1:0]  col_reg;
    logic [ROW_BITS-1:0]  row_reg;

    logic [30:0]          divisor;
    logic [31:0]          trial;
    logic                 take;
    logic [30:0]          rem_step;
    logic [DIV_BITS-1:0]  q_final;
    logic                 div_last;
    logic [32:0]          dx, dy, dz, dz_abs;
    logic [7:0]           w_used, h_used, s_used;
    logic [COL_BITS-1:0]  col_val;
    logic [ROW_BITS-1:0]  row_val;
    logic [SLICE_BITS-1:0] sl_val;

    // one quotient bit per cycle, restoring
    assign divisor  = (state_reg == F_Z) ? nonzero(cfg.slice_height) : nonzero(cfg.pixel_size);
    assign trial    = {rem_reg, dividend_reg[DIV_BITS-1]};
    assign take     = trial >= {1'b0, divisor};
    assign rem_step = take ? 31'(trial - {1'b0, divisor}) : trial[30:0];
    assign q_final  = {quot_reg[DIV_BITS-2:0], take};
    assign div_last = count_reg == '0;

    // negative offsets divide zero, which clamps to column or row zero
    assign dx     = {point_x[31], point_x} - {cfg.origin_x[31], cfg.origin_x};
    assign dy     = {py_reg[31], py_reg} - {cfg.origin_y[31], cfg.origin_y};
    assign dz     = {pz_reg[31], pz_reg} - {cfg.origin_z[31], cfg.origin_z};
    assign dz_abs = dz[32] ? 33'(-dz) : dz;

    assign w_used = used_size(cfg.grid_width, 8'(MAX_COLUMNS));
    assign h_used = used_size(cfg.grid_height, 8'(MAX_ROWS));
    assign s_used = used_size({3'd0, cfg.slice_count}, 8'(MAX_SLICES));

    assign col_val = (q_final[INT_STEPS-1:0] >= 33'(w_used)) ? COL_BITS'(w_used - 8'd1)
                                                             : q_final[COL_BITS-1:0];
    assign row_val = (q_final[INT_STEPS-1:0] >= 33'(h_used)) ? ROW_BITS'(h_used - 8'd1)
                                                             : q_final[ROW_BITS-1:0];
    // slice from the finished quotient held while the word waits
    assign sl_val  = (quot_reg[DIV_BITS-1:FRAC_BITS] >= 33'(s_used)) ?
                     SLICE_BITS'(s_used - 8'd1) : quot_reg[FRAC_BITS+SLICE_BITS-1:FRAC_BITS];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                    state_next = F_X;
            end
            F_X:
            begin
                if (div_last)
                    state_next = F_Y;
            end
            F_Y:
            begin
                if (div_last)
                    state_next = F_Z;
            end
            F_Z:
            begin
                if (div_last)
                    state_next = F_EMIT;
            end
            F_EMIT:
            begin
                if (!job_full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        busy      = 1'b1;
        job_valid = 1'b0;
        case (state_reg)
            F_IDLE: busy = 1'b0;
            F_EMIT: job_valid = 1'b1;
            default:
            begin
                busy      = 1'b1;
                job_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && start)
        begin
            px_reg       <= point_x;
            py_reg       <= point_y;
            pz_reg       <= point_z;
            dividend_reg <= {(dx[32] ? 33'd0 : dx), {FRAC_BITS{1'b0}}};
            quot_reg     <= '0;
            rem_reg      <= '0;
            count_reg    <= CNT_BITS'(INT_STEPS - 1);
        end
        else if (state_reg == F_X || state_reg == F_Y || state_reg == F_Z)
        begin
            if (div_last && state_reg == F_X)
            begin
                col_reg      <= col_val;
                dividend_reg <= {(dy[32] ? 33'd0 : dy), {FRAC_BITS{1'b0}}};
                quot_reg     <= '0;
                rem_reg      <= '0;
                count_reg    <= CNT_BITS'(INT_STEPS - 1);
            end
            else if (div_last && state_reg == F_Y)
            begin
                row_reg      <= row_val;
                dividend_reg <= {dz_abs, {FRAC_BITS{1'b0}}};
                quot_reg     <= '0;
                rem_reg      <= '0;
                count_reg    <= CNT_BITS'(DIV_BITS - 1);
            end
            else
            begin
                dividend_reg <= {dividend_reg[DIV_BITS-2:0], 1'b0};
                quot_reg     <= q_final;
                rem_reg      <= rem_step;
                count_reg    <= count_reg - 1'b1;
            end
        end
    end

    assign job.x    = px_reg;
    assign job.y    = py_reg;
    assign job.z    = pz_reg;
    assign job.col  = col_reg;
    assign job.row  = row_reg;
    assign job.sl   = sl_val;
    assign job.frac = quot_reg[FRAC_BITS-1:0];

endmodule
`default_nettype wire

@@ src/vsom_queue.sv @@
// two-entry queue between front and back
`default_nettype none
module vsom_queue
    import vsom_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  vsom_job_t wr_data,
    output logic      full,
    input  logic      rd_en,
    output vsom_job_t rd_data,
    output logic      nonempty
);

    vsom_job_t  entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_wr, do_rd;

    assign full     = count_reg == 2'd2;
    assign nonempty = count_reg != 2'd0;
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && nonempty;
    assign rd_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule
`default_nettype wire

@@ src/vsom_back.sv @@
// back end: voxel store read-modify-write, z raise and result register
`default_nettype none
module vsom_back
    import vsom_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  vsom_job_t   job,
    input  logic        job_valid,
    output logic        job_pop,
    input  logic [30:0] slice_height,
    output logic        clearing,
    input  logic        pop,
    output logic        empty,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_z,
    output logic [15:0] height_fraction,
    output logic        obstacle
);

    vsom_back_state_t state_reg, state_next;

    logic [CELL_BITS-1:0] cells [0:(2**ADDR_BITS)-1];
    logic [CELL_BITS-1:0] rd_data_reg;
    logic [ADDR_BITS-1:0] clr_cnt_reg;
    vsom_job_t            job_reg;
    logic [47:0]          prod_reg;
    logic                 mark_reg, raise_reg;
    logic                 out_valid_reg;
    logic [31:0]          out_x_reg, out_y_reg, out_z_reg;
    logic [15:0]          frac_out_reg;
    logic                 obstacle_reg;

    logic                 rd_en, wr_en, load_out;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [CELL_BITS-1:0] wr_data;
    logic [FRAC_BITS:0]   old_val, new_val, diff;
    logic                 old_larger, mark;
    logic [33:0]          z_sum;
    logic [31:0]          z_raised;

    assign old_val    = rd_data_reg[FRAC_BITS:0];
    assign new_val    = {1'b0, job_reg.frac};
    assign old_larger = old_val > new_val;
    assign diff       = old_larger ? (old_val - new_val) : (new_val - old_val);
    assign mark       = rd_data_reg[CELL_BITS-1] && (diff > DIFF_LIMIT);

    assign z_sum    = {{2{job_reg.z[31]}}, job_reg.z} + {2'b00, prod_reg[47:FRAC_BITS]}
                    + RAISE_EPS;
    assign z_raised = ($signed(z_sum) > $signed(Q_MAX)) ? Q_MAX[31:0] : z_sum[31:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR:
            begin
                if (clr_cnt_reg == '1)
                    state_next = B_IDLE;
            end
            B_IDLE:
            begin
                if (job_valid)
                    state_next = B_CALC;
            end
            B_CALC: state_next = B_RAISE;
            B_RAISE:
            begin
                if (!out_valid_reg)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        clearing = 1'b0;
        job_pop  = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        load_out = 1'b0;
        wr_addr  = {job_reg.sl, job_reg.row, job_reg.col};
        wr_data  = mark ? {1'b1, ONE_FRAC} : {1'b1, new_val};
        case (state_reg)
            B_CLEAR:
            begin
                clearing = 1'b1;
                wr_en    = 1'b1;
                wr_addr  = clr_cnt_reg;
                wr_data  = '0;
            end
            B_IDLE:
            begin
                job_pop = job_valid;
                rd_en   = job_valid;
            end
            B_CALC: wr_en = 1'b1;
            B_RAISE: load_out = !out_valid_reg;
            default: clearing = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    // voxel store
    always_ff @(posedge clk)
    begin
        if (wr_en)
            cells[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= cells[{job.sl, job.row, job.col}];
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
            job_reg <= job;
        if (state_reg == B_CALC)
        begin
            prod_reg  <= 48'(diff) * 48'(nonzero(slice_height));
            mark_reg  <= mark;
            raise_reg <= mark && old_larger;
        end
        if (load_out)
        begin
            out_x_reg    <= job_reg.x;
            out_y_reg    <= job_reg.y;
            out_z_reg    <= raise_reg ? z_raised : job_reg.z;
            frac_out_reg <= job_reg.frac;
            obstacle_reg <= mark_reg;
        end
    end

    assign empty           = !out_valid_reg;
    assign out_x           = out_x_reg;
    assign out_y           = out_y_reg;
    assign out_z           = out_z_reg;
    assign height_fraction = frac_out_reg;
    assign obstacle        = obstacle_reg;

endmodule
`default_nettype wire

@@ src/voxel_slice_obstacle_marker.sv @@
// top level: configuration registers, front, queue and back
// path: a word passes front states F_X, F_Y, F_Z, F_EMIT, the queue and back states
// B_IDLE, B_CALC, B_RAISE; words enter one at a time, set by the shared one-bit-per-cycle
//   divider (33 steps for column, 33 for row, 49 for slice and fraction)
// reset: the voxel store's 262144 cells are cleared in one pass, full stays high until done
// configuration registers return to their reset values at once
`default_nettype none
module voxel_slice_obstacle_marker
    import vsom_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic [15:0]        height_fraction,
    output logic               obstacle
);

    vsom_cfg_t  cfg_reg;
    vsom_reg_t  reg_sel;
    vsom_job_t  front_job, queue_job;
    logic       front_busy, front_valid, queue_full, queue_nonempty, back_pop, clearing;

    assign reg_sel = vsom_reg_t'(paddr[4:2]);
    assign pready  = 1'b1;
    assign full    = front_busy || clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x     <= '0;
            cfg_reg.origin_y     <= '0;
            cfg_reg.origin_z     <= '0;
            cfg_reg.pixel_size   <= PIXEL_RESET;
            cfg_reg.slice_height <= SLICE_RESET;
            cfg_reg.grid_width   <= WIDTH_RESET;
            cfg_reg.grid_height  <= HEIGHT_RESET;
            cfg_reg.slice_count  <= COUNT_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_sel)
                REG_ORIGIN_X:     cfg_reg.origin_x     <= pwdata;
                REG_ORIGIN_Y:     cfg_reg.origin_y     <= pwdata;
                REG_ORIGIN_Z:     cfg_reg.origin_z     <= pwdata;
                REG_PIXEL_SIZE:   cfg_reg.pixel_size   <= pwdata[30:0];
                REG_SLICE_HEIGHT: cfg_reg.slice_height <= pwdata[30:0];
                REG_GRID_WIDTH:   cfg_reg.grid_width   <= pwdata[7:0];
                REG_GRID_HEIGHT:  cfg_reg.grid_height  <= pwdata[7:0];
                REG_SLICE_COUNT:  cfg_reg.slice_count  <= pwdata[4:0];
                default:          cfg_reg.origin_x     <= cfg_reg.origin_x;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_ORIGIN_X:     prdata = cfg_reg.origin_x;
            REG_ORIGIN_Y:     prdata = cfg_reg.origin_y;
            REG_ORIGIN_Z:     prdata = cfg_reg.origin_z;
            REG_PIXEL_SIZE:   prdata = {1'b0, cfg_reg.pixel_size};
            REG_SLICE_HEIGHT: prdata = {1'b0, cfg_reg.slice_height};
            REG_GRID_WIDTH:   prdata = {24'd0, cfg_reg.grid_width};
            REG_GRID_HEIGHT:  prdata = {24'd0, cfg_reg.grid_height};
            REG_SLICE_COUNT:  prdata = {27'd0, cfg_reg.slice_count};
            default:          prdata = '0;
        endcase
    end

    vsom_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (push && !full),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .cfg       (cfg_reg),
        .job_full  (queue_full),
        .busy      (front_busy),
        .job_valid (front_valid),
        .job       (front_job)
    );

    vsom_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_valid),
        .wr_data  (front_job),
        .full     (queue_full),
        .rd_en    (back_pop),
        .rd_data  (queue_job),
        .nonempty (queue_nonempty)
    );

    vsom_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job             (queue_job),
        .job_valid       (queue_nonempty),
        .job_pop         (back_pop),
        .slice_height    (cfg_reg.slice_height),
        .clearing        (clearing),
        .pop             (pop),
        .empty           (empty),
        .out_x           (out_x),
        .out_y           (out_y),
        .out_z           (out_z),
        .height_fraction (height_fraction),
        .obstacle        (obstacle)
    );

endmodule
`default_nettype wire

@@ src/vsom_checker.sv @@
// port-level checks for the voxel slice obstacle marker
`default_nettype none
module vsom_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [4:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] out_z,
    input logic [15:0] height_fraction,
    input logic        obstacle
);

    // one word at a time: the front is busy right after an accepted word
    a_busy_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("accepted a word back to back");

    // a waiting result holds until popped
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_z) && $stable(height_fraction)
                              && $stable(obstacle)))
        else $error("waiting result changed");

    // origin x reads back what was written
    a_origin_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr == 5'd0) |=>
        (paddr != 5'd0 || prdata == $past(pwdata)))
        else $error("origin x readback mismatch");

endmodule

bind voxel_slice_obstacle_marker vsom_checker u_vsom_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .push            (push),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .out_z           (out_z),
    .height_fraction (height_fraction),
    .obstacle        (obstacle)
);
`default_nettype wire

@@ verif/tb_voxel_slice_obstacle_marker.sv @@
// testbench for the voxel slice obstacle marker: push-side stimulus, apb setup, scoreboard
`default_nettype none
module tb_voxel_slice_obstacle_marker;
    import vsom_pkg::*;

    localparam int IDLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES = 130;
    localparam int RAND_PER_SET = 115;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] frac;
        logic        obstacle;
    } marked_point_t;

    class voxel_scoreboard;
        logic signed [31:0] org_x, org_y, org_z;
        logic [30:0]        pix, slh;
        logic [7:0]         gw, gh;
        logic [4:0]         gs;
        logic [17:0]        cells [0:262143];   // bit 17 valid, 16:0 value up to 1.0
        marked_point_t      pending_q[$];
        int                 errors;

        function new();
            org_x = 0;
            org_y = 0;
            org_z = 0;
            pix   = PIXEL_RESET;
            slh   = SLICE_RESET;
            gw    = WIDTH_RESET;
            gh    = HEIGHT_RESET;
            gs    = COUNT_RESET;
            errors = 0;
            foreach (cells[i])
                cells[i] = '0;
        endfunction

        function void write_reg(vsom_reg_t r, logic [31:0] v);
            case (r)
                REG_ORIGIN_X:     org_x = v;
                REG_ORIGIN_Y:     org_y = v;
                REG_ORIGIN_Z:     org_z = v;
                REG_PIXEL_SIZE:   pix = v[30:0];
                REG_SLICE_HEIGHT: slh = v[30:0];
                REG_GRID_WIDTH:   gw = v[7:0];
                REG_GRID_HEIGHT:  gh = v[7:0];
                default:          gs = v[4:0];
            endcase
        endfunction

        function longint floor_quot(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) != 0 && a < 0)
                q--;
            return q;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void note_point(logic signed [31:0] x, logic signed [31:0] y,
                                 logic signed [31:0] z);
            longint cell_w, sig, col, row, sl, dz, frac, oldv, diff, zout;
            int unsigned idx;
            logic [17:0] stored;
            marked_point_t m;
            cell_w = (pix == 0) ? 1 : longint'(pix);
            sig    = (slh == 0) ? 1 : longint'(slh);
            col = clip(floor_quot(longint'(x) - longint'(org_x), cell_w), 0,
                       clip(gw, 1, MAX_COLUMNS) - 1);
            row = clip(floor_quot(longint'(y) - longint'(org_y), cell_w), 0,
                       clip(gh, 1, MAX_ROWS) - 1);
            dz = longint'(z) - longint'(org_z);
            if (dz < 0)
                dz = -dz;
            sl   = clip(dz / sig, 0, clip(gs, 1, MAX_SLICES) - 1);
            frac = ((dz % sig) << FRAC_BITS) / sig;
            idx  = 32'(sl * MAX_ROWS * MAX_COLUMNS + row * MAX_COLUMNS + col);
            stored = cells[idx];
            zout = z;
            m.obstacle = 1'b0;
            cells[idx] = {1'b1, 17'(frac)};
            if (stored[17])
            begin
                oldv = stored[16:0];
                diff = (oldv > frac) ? oldv - frac : frac - oldv;
                if (diff > longint'(DIFF_LIMIT))
                begin
                    m.obstacle = 1'b1;
                    cells[idx] = {1'b1, ONE_FRAC};
                    if (oldv > frac)
                    begin
                        zout = longint'(z) + (((oldv - frac) * sig) >>> FRAC_BITS)
                             + longint'(RAISE_EPS);
                        if (zout > longint'(Q_MAX))
                            zout = longint'(Q_MAX);
                    end
                end
            end
            m.x = x;
            m.y = y;
            m.z = zout[31:0];
            m.frac = frac[15:0];
            pending_q = {pending_q, m};
        endfunction

        function void check_result(marked_point_t got);
            marked_point_t want;
            if (pending_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: x=%h y=%h z=%h frac=%h obs=%b",
                             got.x, got.y, got.z, got.frac, got.obstacle);
                return;
            end
            want = pending_q.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                got.frac !== want.frac || got.obstacle !== want.obstacle)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp x=%h y=%h z=%h frac=%h obs=%b, ",
                              "got x=%h y=%h z=%h frac=%h obs=%b"},
                             want.x, want.y, want.z, want.frac, want.obstacle,
                             got.x, got.y, got.z, got.frac, got.obstacle);
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic push, full, empty, pop;
    logic signed [31:0] point_x, point_y, point_z;
    logic signed [31:0] out_x, out_y, out_z;
    logic [15:0] height_fraction;
    logic obstacle;

    voxel_scoreboard sb;
    bit quiet;
    int idle_count;
    logic signed [31:0] last_x, last_y, last_z;

    voxel_slice_obstacle_marker dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        marked_point_t got;
        if (rst_n)
        begin
            if (push && !full)
                sb.note_point(point_x, point_y, point_z);
            if (pop && !empty)
            begin
                got.x = out_x;
                got.y = out_y;
                got.z = out_z;
                got.frac = height_fraction;
                got.obstacle = obstacle;
                sb.check_result(got);
            end
            if ((push && !full) || (pop && !empty))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // receiver with random stall bursts
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                @(negedge clk);
                pop = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
            else
            begin
                @(negedge clk);
                pop = 1'b1;
            end
        end
    end

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            @(negedge clk);
            push = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
        @(negedge clk);
        push = 1'b1;
        point_x = x;
        point_y = y;
        point_z = z;
        last_x = x;
        last_y = y;
        last_z = z;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        push = 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(vsom_reg_t r, logic [31:0] v);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {r, 2'b00};
        pwdata = v;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        sb.write_reg(r, v);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic load_setup(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                              logic [31:0] ps, logic [31:0] sh,
                              logic [7:0] w, logic [7:0] h, logic [4:0] n);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_PIXEL_SIZE, ps);
        write_reg(REG_SLICE_HEIGHT, sh);
        write_reg(REG_GRID_WIDTH, {24'd0, w});
        write_reg(REG_GRID_HEIGHT, {24'd0, h});
        write_reg(REG_SLICE_COUNT, {27'd0, n});
    endtask

    function automatic longint rnd_below(longint n);
        longint r;
        r = longint'({$urandom, $urandom} >> 1);
        return (n <= 0) ? 0 : r % n;
    endfunction

    // a mix of fully random points, points near the grid and repeats of the last x and y with a nudged z
    task automatic send_random(int count);
        longint ps, sh, x, y, z;
        int k;
        for (k = 0; k < count; k++)
        begin
            ps = (sb.pix == 0) ? 1 : sb.pix;
            sh = (sb.slh == 0) ? 1 : sb.slh;
            case ($urandom_range(0, 9))
                0, 1, 2:
                    send_point($urandom, $urandom, $urandom);
                3, 4, 5:
                begin
                    z = longint'(last_z) + rnd_below(sh / 8 + 2) - sh / 16;
                    send_point(last_x, last_y, z[31:0]);
                end
                default:
                begin
                    x = longint'(sb.org_x) + rnd_below(ps * (sb.gw % 8 + 2));
                    y = longint'(sb.org_y) + rnd_below(ps * (sb.gh % 8 + 2));
                    z = longint'(sb.org_z) + rnd_below(2 * sh * (sb.gs % 8 + 2))
                      - sh * (sb.gs % 8 + 2);
                    send_point(x[31:0], y[31:0], z[31:0]);
                end
            endcase
        end
    endtask

    initial
    begin
        sb = new();
        quiet = 1'b0;
        idle_count = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        push = 1'b0;
        point_x = '0;
        point_y = '0;
        point_z = '0;
        last_x = '0;
        last_y = '0;
        last_z = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset setup: empty voxel, raise, marked voxel, small change, mark from below
        send_point(32'd0, 32'd0, 32'd58982);
        send_point(32'd0, 32'd0, 32'd6554);
        send_point(32'd0, 32'd0, 32'd32768);
        send_point(32'd65536, 32'd0, 32'd13107);
        send_point(32'd65536, 32'd0, 32'd14418);
        send_point(32'd65536, 32'd0, 32'd58982);
        // clamping at the top, then a raise that saturates
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_0010);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'hFFFD_0000, 32'h0005_0000, 32'hFFFC_FF9C);
        send_point(32'h0002_8000, 32'h0003_4000, 32'h0004_F000);
        send_point(32'h0002_8000, 32'h0003_4000, 32'h0004_1000);
        send_random(RAND_PER_SET);

        // hold off until every word is back
        wait_drained();
        load_setup(32'hFFFC_8000, 32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000,
                   32'h0000_4000, 8'd4, 8'd3, 5'd5);
        send_random(RAND_PER_SET);

        wait_drained();
        load_setup(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0, 8'd0, 5'd0);
        send_random(40);

        wait_drained();
        load_setup(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                   32'h7FFF_FFFF, 8'd255, 8'd200, 5'd31);
        send_random(RAND_PER_SET);

        wait_drained();
        load_setup(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0003_0000,
                   32'h0002_0000, 8'd128, 8'd1, 5'd16);
        send_random(RAND_PER_SET);

        wait_drained();
        load_setup(32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000, 8'd2, 8'd2, 5'd2);
        send_random(RAND_PER_SET);

        quiet = 1'b1;
        send_random(RAND_PER_SET);

        wait_drained();
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
src/vsom_pkg.sv
src/vsom_front.sv
src/vsom_queue.sv
src/vsom_back.sv
src/voxel_slice_obstacle_marker.sv
src/vsom_checker.sv
verif/tb_voxel_slice_obstacle_marker.sv
